// ----- src/lss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int TICKET_BITS_DEF = 16;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 6;
  localparam int TIXIN_W = 16;
  localparam int CHAN_W = 16;
  localparam int TOTAL_W = 22;
  localparam int MINT_W = 16;
  localparam int SEED_W = 31;
  localparam int ST_W = 3;

  localparam logic [KIND_W-1:0] K_PICK = 3'd0;
  localparam logic [KIND_W-1:0] K_ADMIT = 3'd1;
  localparam logic [KIND_W-1:0] K_YIELD = 3'd2;
  localparam logic [KIND_W-1:0] K_SLEEP = 3'd3;
  localparam logic [KIND_W-1:0] K_EXIT = 3'd4;
  localparam logic [KIND_W-1:0] K_WAKE = 3'd5;
  localparam logic [KIND_W-1:0] K_FREE = 3'd6;

  localparam logic [ST_W-1:0] ST_UNUSED = 3'd0;
  localparam logic [ST_W-1:0] ST_SLEEPING = 3'd1;
  localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd2;
  localparam logic [ST_W-1:0] ST_RUNNING = 3'd3;
  localparam logic [ST_W-1:0] ST_ZOMBIE = 3'd4;

  localparam logic [SEED_W-1:0] PM_MOD = 31'h7fffffff;
  localparam logic [15:0] PM_MUL = 16'd48271;
  localparam logic [15:0] PM_Q = 16'(32'h7fffffff / 32'd48271);
  localparam logic [15:0] PM_R = 16'(32'h7fffffff % 32'd48271);
  // Rounded-up reciprocal of PM_Q scaled by 2^47; exact quotient for any 31-bit value.
  localparam logic [31:0] PM_QINV = 32'((64'd1 << 47) / 64'(PM_Q) + 64'd1);

  localparam logic CFG_MINT = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch input item, start at slot zero
    logic clr_step;   // clearing pass: clear entry at scan index
    logic rd;         // issue table read at scan index
    logic srd;        // issue table read at the item's slot
    logic scan;       // process read data of previous index
    logic rng_start;  // start generator step
    logic div_start;  // start draw mod total
    logic single;     // apply single-slot item update
    logic commit;     // load output register
  } lss_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index is the last slot
    logic rng_done;
    logic div_done;
    logic found_hit;  // running sum reached target
    logic total_nz;   // tickets in play
  } lss_sts_t;
endpackage
`default_nettype wire

// ----- src/lss_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lss_datapath #(
  parameter int SLOTS = lss_pkg::SLOTS_DEF,
  parameter int TICKET_BITS = lss_pkg::TICKET_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire lss_pkg::lss_cmd_t cmd,
  output lss_pkg::lss_sts_t sts,
  input  wire logic [lss_pkg::KIND_W-1:0] in_kind,
  input  wire logic [lss_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [lss_pkg::TIXIN_W-1:0] in_ticket_count,
  input  wire logic [lss_pkg::CHAN_W-1:0] in_channel,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [lss_pkg::SEED_W-1:0] cfg_data,
  output logic out_granted,
  output logic [lss_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic [lss_pkg::TOTAL_W-1:0] out_ticket_total
);
  import lss_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = TICKET_BITS + IW + 1;
  localparam int TGT_W = (SUM_W > 33) ? SUM_W : 33;

  logic [ST_W-1:0] st_mem [SLOTS];
  logic [TICKET_BITS-1:0] tk_mem [SLOTS];
  logic [CHAN_W-1:0] ch_mem [SLOTS];
  logic [ST_W-1:0] st_rd;
  logic [TICKET_BITS-1:0] tk_rd;
  logic [CHAN_W-1:0] ch_rd;

  logic [KIND_W-1:0] kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TICKET_BITS-1:0] tix_r;
  logic [CHAN_W-1:0] chan_r;
  logic [IW-1:0] idx_r, pidx_r;
  logic [SUM_W-1:0] total_r, total_nxt, cum_r;
  logic [TGT_W-1:0] target_r;
  logic [MINT_W-1:0] mint_r;
  logic [SEED_W-1:0] rng_r;
  logic found_r, hit_r;
  logic [IW-1:0] sel_r;
  logic rng_done_r, div_done_r;

  // Scan/clear index and the slot addressed by single-slot items.
  logic [IW-1:0] addr;
  logic slot_ok;
  assign slot_ok = ({{(32-SLOT_W){1'b0}}, slot_r} < SLOTS);
  assign addr = (cmd.srd) ? IW'(slot_r) : idx_r;

  // Write port control.
  logic we;
  logic [ST_W-1:0] wst;
  logic [TICKET_BITS-1:0] wtk;
  logic [CHAN_W-1:0] wch;
  logic wtk_en, wch_en;
  logic [IW-1:0] waddr;

  always_comb begin
    we = 1'b0; wst = st_rd; wtk = tk_rd; wch = chan_r; wtk_en = 1'b0; wch_en = 1'b0;
    waddr = pidx_r;
    total_nxt = total_r;
    if (cmd.clr_step) begin
      we = 1'b1; wst = ST_UNUSED; wtk = '0; wtk_en = 1'b1; waddr = idx_r;
    end else if (cmd.scan && kind_r == K_WAKE) begin
      if (st_rd == ST_SLEEPING && ch_rd == chan_r) begin
        we = 1'b1; wst = ST_RUNNABLE;
        total_nxt = total_r + SUM_W'(tk_rd);
      end
    end else if (cmd.single && slot_ok) begin
      waddr = IW'(slot_r);
      case (kind_r)
        K_ADMIT: if (st_rd == ST_UNUSED) begin
          we = 1'b1; wst = ST_RUNNABLE; wtk = tix_r; wtk_en = 1'b1;
          total_nxt = total_r + SUM_W'(tix_r);
        end
        K_YIELD: if (st_rd == ST_SLEEPING) begin
          we = 1'b1; wst = ST_RUNNABLE; total_nxt = total_r + SUM_W'(tk_rd);
        end else if (st_rd == ST_RUNNABLE || st_rd == ST_RUNNING) begin
          we = 1'b1; wst = ST_RUNNABLE;
        end
        K_SLEEP: if (st_rd == ST_SLEEPING || st_rd == ST_RUNNABLE ||
                     st_rd == ST_RUNNING) begin
          we = 1'b1; wst = ST_SLEEPING; wch_en = 1'b1;
          if (st_rd != ST_SLEEPING) total_nxt = total_r - SUM_W'(tk_rd);
        end
        K_EXIT: if (st_rd != ST_UNUSED) begin
          we = 1'b1; wst = ST_ZOMBIE;
          if (st_rd == ST_RUNNABLE || st_rd == ST_RUNNING)
            total_nxt = total_r - SUM_W'(tk_rd);
        end
        K_FREE: begin
          we = 1'b1; wst = ST_UNUSED; wtk = '0; wtk_en = 1'b1; wch = '0; wch_en = 1'b1;
          if (st_rd == ST_RUNNABLE || st_rd == ST_RUNNING)
            total_nxt = total_r - SUM_W'(tk_rd);
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.commit && kind_r == K_PICK && found_r) begin
      we = 1'b1; wst = ST_RUNNING; waddr = sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) st_mem[waddr] <= wst;
    if (we && wtk_en) tk_mem[waddr] <= wtk;
    if (we && wch_en) ch_mem[waddr] <= wch;
    if (cmd.rd || cmd.srd) begin
      st_rd <= st_mem[addr];
      tk_rd <= tk_mem[addr];
      ch_rd <= ch_mem[addr];
    end
  end

  // Generator: Schrage form. The quotient by PM_Q comes from a reciprocal
  // multiply, then two narrow multiplies.
  logic [1:0] rng_ph_r;
  logic [62:0] qm_r;
  logic [15:0] hi_r, lo_r;
  logic [31:0] hq;
  logic [31:0] a_r, b_r;
  logic [31:0] rng_a;
  assign hq = {16'd0, qm_r[62:47]} * {16'd0, PM_Q};
  assign rng_a = (a_r > b_r) ? (a_r - b_r) : (a_r + ({1'b0, PM_MOD} - b_r));

  // Draw modulo total: restoring division, one bit a cycle.
  logic [5:0] dcnt_r;
  logic [SEED_W-1:0] dq_r;
  logic [SUM_W:0] drem_r;
  logic div_busy_r;
  logic [SUM_W:0] dshift;
  assign dshift = {drem_r[SUM_W-1:0], dq_r[SEED_W-1]};

  logic [TGT_W-1:0] cum_ext;
  logic [SUM_W-1:0] cum_add;
  assign cum_add = cum_r + SUM_W'(tk_rd);
  assign cum_ext = TGT_W'(cum_add);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mint_r <= MINT_W'(1);
      rng_r <= SEED_W'(1);
      total_r <= '0;
      rng_ph_r <= '0;
      div_busy_r <= 1'b0;
      rng_done_r <= 1'b0;
      div_done_r <= 1'b0;
      idx_r <= '0;
    end else begin
      rng_done_r <= 1'b0;
      div_done_r <= 1'b0;
      total_r <= total_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_MINT) mint_r <= cfg_data[MINT_W-1:0];
        else rng_r <= cfg_data;
      end
      if (cmd.load) idx_r <= '0;
      else if (cmd.rd || cmd.clr_step) idx_r <= idx_r + 1'b1;
      pidx_r <= idx_r;
      // generator
      if (cmd.rng_start) begin
        qm_r <= 63'(rng_r) * 63'(PM_QINV);
        rng_ph_r <= 2'd1;
      end else if (rng_ph_r == 2'd1) begin
        hi_r <= qm_r[62:47];
        lo_r <= 16'(rng_r - hq[SEED_W-1:0]);
        rng_ph_r <= 2'd2;
      end else if (rng_ph_r == 2'd2) begin
        a_r <= {16'd0, lo_r} * {16'd0, PM_MUL};
        b_r <= {16'd0, hi_r} * {16'd0, PM_R};
        rng_ph_r <= 2'd3;
      end else if (rng_ph_r == 2'd3) begin
        rng_r <= rng_a[SEED_W-1:0];
        rng_ph_r <= 2'd0;
        rng_done_r <= 1'b1;
      end
      // divider
      if (cmd.div_start) begin
        dq_r <= rng_r; drem_r <= '0; dcnt_r <= 6'(SEED_W); div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        dq_r <= {dq_r[SEED_W-2:0], 1'b0};
        if (dshift >= {1'b0, total_r}) drem_r <= dshift - {1'b0, total_r};
        else drem_r <= dshift;
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == 6'd1) begin
          div_busy_r <= 1'b0; div_done_r <= 1'b1;
        end
      end
      if (div_done_r)
        target_r <= TGT_W'(drem_r[SUM_W-1:0]) + TGT_W'(mint_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind; slot_r <= in_slot; chan_r <= in_channel;
      tix_r <= TICKET_BITS'(in_ticket_count);
      cum_r <= '0; found_r <= 1'b0; hit_r <= 1'b0; sel_r <= '0;
    end else if (cmd.scan && kind_r == K_PICK && !hit_r && st_rd == ST_RUNNABLE) begin
      cum_r <= cum_add; sel_r <= pidx_r; found_r <= 1'b1;
      if (cum_ext >= target_r) hit_r <= 1'b1;
    end
    if (cmd.commit) begin
      out_granted <= (kind_r == K_PICK) && found_r;
      out_chosen_slot <= (kind_r == K_PICK && found_r) ? SLOT_W'(sel_r) : '0;
      out_ticket_total <= TOTAL_W'(total_r);
    end
  end

  assign sts = '{scan_last: (idx_r == IW'(SLOTS - 1)), rng_done: rng_done_r,
                 div_done: div_done_r, found_hit: hit_r, total_nz: |total_r};
endmodule
`default_nettype wire

// ----- src/lss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lss_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [lss_pkg::KIND_W-1:0] in_kind,
  output logic out_valid,
  input  wire logic out_ready,
  output lss_pkg::lss_cmd_t cmd,
  input  wire lss_pkg::lss_sts_t sts
);
  import lss_pkg::*;
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SRD = 4'd2, S_SAPP = 4'd3,
    S_RNG = 4'd4, S_DIV = 4'd5, S_SCAN = 4'd6, S_LAST = 4'd7, S_COMMIT = 4'd8,
    S_OUT = 4'd9, S_DIVW = 4'd10;
  logic [3:0] state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic first_r, rng_go_r;

  assign out_valid = ov_r;
  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        if (in_kind == K_PICK) state_nxt = sts.total_nz ? S_RNG : S_COMMIT;
        else if (in_kind == K_WAKE) state_nxt = S_SCAN;
        else state_nxt = S_SRD;
      end
      S_SRD: begin cmd.srd = 1'b1; state_nxt = S_SAPP; end
      S_SAPP: begin cmd.single = 1'b1; state_nxt = S_COMMIT; end
      S_RNG: begin
        if (sts.rng_done) begin cmd.div_start = 1'b1; state_nxt = S_DIV; end
      end
      S_DIV: if (sts.div_done) state_nxt = S_DIVW;
      S_DIVW: state_nxt = S_SCAN;
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.scan_last) state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_COMMIT;
      S_COMMIT: begin cmd.commit = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
    // Read data arrives in the cycle after the address; process it then.
    if ((state_r == S_SCAN && !first_r) || state_r == S_LAST) cmd.scan = 1'b1;
    if (state_r == S_RNG && rng_go_r) cmd.rng_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; ov_r <= 1'b0; first_r <= 1'b0; rng_go_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
      first_r <= (state_r != S_SCAN);
      rng_go_r <= (state_r == S_IDLE);
    end
  end
endmodule
`default_nettype wire

// ----- src/lottery_slot_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Lottery scheduler over a table of SLOTS slots held in three arrays. After reset a
// clearing pass empties the table before items are taken. One item is processed
// at a time. Wake walks the whole table; pick, when tickets are in play, steps the
// generator, reduces the draw by the total one bit a cycle and walks the table.
// The single table read port sets the walk length.
module lottery_slot_scheduler #(
  parameter int SLOTS = lss_pkg::SLOTS_DEF,
  parameter int TICKET_BITS = lss_pkg::TICKET_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [lss_pkg::KIND_W-1:0] in_kind,
  input  wire logic [lss_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [lss_pkg::TIXIN_W-1:0] in_ticket_count,
  input  wire logic [lss_pkg::CHAN_W-1:0] in_channel,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_granted,
  output logic [lss_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic [lss_pkg::TOTAL_W-1:0] out_ticket_total,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [lss_pkg::SEED_W-1:0] cfg_data
);
  import lss_pkg::*;
  lss_cmd_t cmd;
  lss_sts_t sts;
  assign cfg_ready = 1'b1;

  lss_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .out_valid, .out_ready,
    .cmd, .sts
  );

  lss_datapath #(.SLOTS(SLOTS), .TICKET_BITS(TICKET_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_kind, .in_slot, .in_ticket_count, .in_channel,
    .cfg_we(cfg_valid), .cfg_index, .cfg_data,
    .out_granted, .out_chosen_slot, .out_ticket_total
  );
endmodule
`default_nettype wire
